[rtl/tpd_pkg.sv]
// Shared types, codes and helper functions for the port scan detector.
// No dependencies; every other file imports this package.
`default_nettype none
package tpd_pkg;

   localparam int DEF_HASH_BITS = 10;
   localparam int DEF_WAYS      = 4;
   localparam int DEF_HOSTS     = 8;

   // host count field holds list lengths up to 127
   localparam int HC_W = 7;

   localparam logic [2:0] STAT_IGNORED = 3'd0;
   localparam logic [2:0] STAT_DECIDED = 3'd1;
   localparam logic [2:0] STAT_REPEAT  = 3'd2;
   localparam logic [2:0] STAT_PENDING = 3'd3;
   localparam logic [2:0] STAT_BENIGN  = 3'd4;
   localparam logic [2:0] STAT_SCANNER = 3'd5;
   localparam logic [2:0] STAT_FULL    = 3'd6;

   localparam logic [1:0] DEC_PENDING = 2'd0;
   localparam logic [1:0] DEC_BENIGN  = 2'd1;
   localparam logic [1:0] DEC_SCANNER = 2'd2;

   localparam logic [2:0] REG_SUCCESS_STEP = 3'd0;
   localparam logic [2:0] REG_FAILURE_STEP = 3'd1;
   localparam logic [2:0] REG_LOWER_THR    = 3'd2;
   localparam logic [2:0] REG_UPPER_THR    = 3'd3;
   localparam logic [2:0] REG_PENDING_LIFE = 3'd4;
   localparam logic [2:0] REG_BENIGN_LIFE  = 3'd5;
   localparam logic [2:0] REG_SCANNER_LIFE = 3'd6;
   localparam logic [2:0] REG_CLEANUP      = 3'd7;

   localparam logic [31:0] CRC_POLY = 32'hEDB88320;
   localparam logic [31:0] ALL_ONES = 32'hFFFFFFFF;

   typedef struct packed {
      logic [15:0] success_step;
      logic [15:0] failure_step;
      logic [15:0] lower_threshold;
      logic [15:0] upper_threshold;
      logic [31:0] pending_lifetime;
      logic [31:0] benign_lifetime;
      logic [31:0] scanner_lifetime;
      logic [31:0] cleanup_interval;
   } cfg_type;

   typedef struct packed {
      logic            valid;
      logic [31:0]     source;
      logic [31:0]     subnet;
      logic [31:0]     mask;
      logic [15:0]     failed;
      logic [15:0]     success;
      logic [15:0]     score;
      logic [1:0]      decision;
      logic [31:0]     expiry;
      logic [HC_W-1:0] hosts;
   } entry_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] source;
      logic [31:0] subnet;
      logic [31:0] mask;
      logic [15:0] failed;
      logic [15:0] success;
      logic [15:0] score;
   } res_type;

   function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
      logic [31:0] r;
      r = c ^ {24'd0, b};
      for (int i = 0; i < 8; i++) begin
         r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
      end
      return r;
   endfunction

   // now + life, saturating at all ones
   function automatic logic [31:0] later(input logic [31:0] now, input logic [31:0] life);
      logic [32:0] t;
      t = {1'b0, now} + {1'b0, life};
      return t[32] ? ALL_ONES : t[31:0];
   endfunction

   function automatic logic [15:0] sat_inc(input logic [15:0] v);
      return (v == 16'hFFFF) ? v : v + 16'd1;
   endfunction

   function automatic res_type entry_result(input logic [2:0] st, input entry_type e);
      res_type r;
      r.status  = st;
      r.source  = e.source;
      r.subnet  = e.subnet;
      r.mask    = e.mask;
      r.failed  = e.failed;
      r.success = e.success;
      r.score   = e.score;
      return r;
   endfunction

endpackage
`default_nettype wire

[rtl/tpd_csr.sv]
// Configuration register file behind the APB-style port.
// Depends on tpd_pkg.
`default_nettype none
module tpd_csr (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          csr_psel,
   input  wire logic          csr_penable,
   input  wire logic          csr_pwrite,
   input  wire logic [4:0]    csr_paddr,
   input  wire logic [31:0]   csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready,
   output tpd_pkg::cfg_type   cfg
);
   import tpd_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   logic [2:0] idx;
   logic       wr;

   assign csr_pready = 1'b1;
   assign idx        = csr_paddr[4:2];
   assign wr         = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         unique case (idx)
            REG_SUCCESS_STEP: cfg_in.success_step     = csr_pwdata[15:0];
            REG_FAILURE_STEP: cfg_in.failure_step     = csr_pwdata[15:0];
            REG_LOWER_THR:    cfg_in.lower_threshold  = csr_pwdata[15:0];
            REG_UPPER_THR:    cfg_in.upper_threshold  = csr_pwdata[15:0];
            REG_PENDING_LIFE: cfg_in.pending_lifetime = csr_pwdata;
            REG_BENIGN_LIFE:  cfg_in.benign_lifetime  = csr_pwdata;
            REG_SCANNER_LIFE: cfg_in.scanner_lifetime = csr_pwdata;
            REG_CLEANUP:      cfg_in.cleanup_interval = csr_pwdata;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_SUCCESS_STEP: csr_prdata = {16'd0, cfg_ff.success_step};
         REG_FAILURE_STEP: csr_prdata = {16'd0, cfg_ff.failure_step};
         REG_LOWER_THR:    csr_prdata = {16'd0, cfg_ff.lower_threshold};
         REG_UPPER_THR:    csr_prdata = {16'd0, cfg_ff.upper_threshold};
         REG_PENDING_LIFE: csr_prdata = cfg_ff.pending_lifetime;
         REG_BENIGN_LIFE:  csr_prdata = cfg_ff.benign_lifetime;
         REG_SCANNER_LIFE: csr_prdata = cfg_ff.scanner_lifetime;
         REG_CLEANUP:      csr_prdata = cfg_ff.cleanup_interval;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.success_step     <= 16'hFE9D;
         cfg_ff.failure_step     <= 16'd355;
         cfg_ff.lower_threshold  <= 16'hF47D;
         cfg_ff.upper_threshold  <= 16'd2947;
         cfg_ff.pending_lifetime <= 32'd3600;
         cfg_ff.benign_lifetime  <= 32'd3600;
         cfg_ff.scanner_lifetime <= 32'd86400;
         cfg_ff.cleanup_interval <= 32'd10;
      end else begin
         cfg_ff <= cfg_in;
      end
   end
endmodule
`default_nettype wire

[rtl/tpd_hash.sv]
// Bucket hash: CRC-32 over the two low address bytes, one byte per cycle.
// Depends on tpd_pkg.
`default_nettype none
module tpd_hash #(
   parameter int HASH_BITS = tpd_pkg::DEF_HASH_BITS
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 run,
   input  wire logic [15:0]          ip,
   output logic                      done,
   output logic [HASH_BITS-1:0]      bucket
);
   import tpd_pkg::*;

   logic [1:0]  step_ff, step_in;
   logic [31:0] crc_ff, crc_in;

   always_comb begin
      step_in = step_ff;
      crc_in  = crc_ff;
      if (!run) begin
         step_in = 2'd0;
         crc_in  = ALL_ONES;
      end else if (step_ff == 2'd0) begin
         crc_in  = crc_byte(crc_ff, ip[15:8]);
         step_in = 2'd1;
      end else if (step_ff == 2'd1) begin
         crc_in  = crc_byte(crc_ff, ip[7:0]);
         step_in = 2'd2;
      end
   end

   assign done   = run && (step_ff == 2'd2);
   assign bucket = ~crc_ff[HASH_BITS-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= 2'd0;
         crc_ff  <= ALL_ONES;
      end else begin
         step_ff <= step_in;
         crc_ff  <= crc_in;
      end
   end
endmodule
`default_nettype wire

[rtl/tpd_store.sv]
// Source table and destination lists, one read and one write port each,
// registered read data. Depends on tpd_pkg.
`default_nettype none
module tpd_store #(
   parameter int SLOTS  = 4096,
   parameter int SLOT_W = 12,
   parameter int DESTS  = 32768,
   parameter int DEST_W = 15
) (
   input  wire logic                 clock,
   input  wire logic [SLOT_W-1:0]    ent_raddr,
   output tpd_pkg::entry_type        ent_rdata,
   input  wire logic                 ent_we,
   input  wire logic [SLOT_W-1:0]    ent_waddr,
   input  tpd_pkg::entry_type        ent_wdata,
   input  wire logic [DEST_W-1:0]    dst_raddr,
   output logic [31:0]               dst_rdata,
   input  wire logic                 dst_we,
   input  wire logic [DEST_W-1:0]    dst_waddr,
   input  wire logic [31:0]          dst_wdata
);
   import tpd_pkg::*;

   entry_type   ent_mem [SLOTS];
   logic [31:0] dst_mem [DESTS];

   always_ff @(posedge clock) begin
      if (ent_we) begin
         ent_mem[ent_waddr] <= ent_wdata;
      end
      ent_rdata <= ent_mem[ent_raddr];
   end

   always_ff @(posedge clock) begin
      if (dst_we) begin
         dst_mem[dst_waddr] <= dst_wdata;
      end
      dst_rdata <= dst_mem[dst_raddr];
   end
endmodule
`default_nettype wire

[rtl/trw_portscan_detector.sv]
// Threshold random walk port scan detector.
//
// req channel: one connection record per request (addresses, time, flags).
// rsp channel: one result per request, in order. csr port: eight registers;
// the user must write them only while idle (unchecked); pready is tied high.
//
// After reset the block runs a clearing pass over all 2^HASH_BITS * WAYS
// slots of the source table (4096 by default), one slot per cycle, with
// req_tready low. Then each request goes through one sequencer that
// drives a single table read port: hashing, reading and checking each way,
// updating the entry, reading and comparing each stored destination,
// inserting, widening the prefix bit by bit until it covers dst, deciding
// and emitting. When cleanup_interval has passed, a request with SYN first
// sweeps the whole table, reading each slot and clearing expired entries.
// Records without SYN skip the table and get an ignored result. The
// result sits in an output register; if the receiver stalls, the next
// request is still accepted and runs until its own result is ready.
// Depends on tpd_pkg, tpd_csr, tpd_hash and tpd_store.
`default_nettype none
module trw_portscan_detector #(
   parameter int HASH_BITS       = tpd_pkg::DEF_HASH_BITS,
   parameter int WAYS            = tpd_pkg::DEF_WAYS,
   parameter int HOSTS_PER_ENTRY = tpd_pkg::DEF_HOSTS
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_tvalid,
   output logic                req_tready,
   input  wire logic [95:0]    req_tdata,  // src_ip, dst_ip, now
   input  wire logic [2:0]     req_tuser,  // src_syn, reply_syn, reply_ack
   output logic                rsp_tvalid,
   input  wire logic           rsp_tready,
   // source_addr, target_subnet, target_mask, failed_count, success_count, score
   output logic [143:0]        rsp_tdata,
   output logic [2:0]          rsp_tuser,  // status
   input  wire logic           csr_psel,
   input  wire logic           csr_penable,
   input  wire logic           csr_pwrite,
   input  wire logic [4:0]     csr_paddr,
   input  wire logic [31:0]    csr_pwdata,
   output logic [31:0]         csr_prdata,
   output logic                csr_pready
);
   import tpd_pkg::*;

   localparam int SLOTS  = (1 << HASH_BITS) * WAYS;
   localparam int SLOT_W = $clog2(SLOTS);
   localparam int DESTS  = SLOTS * HOSTS_PER_ENTRY;
   localparam int DEST_W = $clog2(DESTS);
   localparam int WAY_W  = $clog2(WAYS + 1);

   localparam logic [3:0] S_CLEAR    = 4'd0;
   localparam logic [3:0] S_IDLE     = 4'd1;
   localparam logic [3:0] S_SWEEP_RD = 4'd2;
   localparam logic [3:0] S_SWEEP_WR = 4'd3;
   localparam logic [3:0] S_HASH     = 4'd4;
   localparam logic [3:0] S_WAY_RD   = 4'd5;
   localparam logic [3:0] S_WAY_CHK  = 4'd6;
   localparam logic [3:0] S_UPDATE   = 4'd7;
   localparam logic [3:0] S_HOST_RD  = 4'd8;
   localparam logic [3:0] S_HOST_CHK = 4'd9;
   localparam logic [3:0] S_INSERT   = 4'd10;
   localparam logic [3:0] S_AGG      = 4'd11;
   localparam logic [3:0] S_DECIDE   = 4'd12;
   localparam logic [3:0] S_EMIT     = 4'd13;

   cfg_type cfg;

   logic [3:0]        state_ff, state_in;
   logic [SLOT_W-1:0] idx_ff, idx_in;
   logic [SLOT_W-1:0] base_ff, base_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [SLOT_W-1:0] free_ff, free_in;
   logic              has_free_ff, has_free_in;
   logic [WAY_W-1:0]  way_ff, way_in;
   logic [HC_W-1:0]   host_ff, host_in;
   logic [31:0]       src_ff, src_in, dst_ff, dst_in, now_ff, now_in;
   logic              ok_ff, ok_in;
   logic [31:0]       last_ff, last_in;
   entry_type         ent_ff, ent_in;
   res_type           res_ff, res_in;
   res_type           out_ff, out_in;
   logic              out_vld_ff, out_vld_in;

   logic              hash_done;
   logic [HASH_BITS-1:0] bucket;

   logic [SLOT_W-1:0] ent_raddr, ent_waddr, way_slot;
   entry_type         ent_rdata, ent_wdata;
   logic              ent_we;
   logic [DEST_W-1:0] dst_raddr, dst_waddr;
   logic [31:0]       dst_rdata;
   logic              dst_we;

   logic              req_acc;
   logic [32:0]       sweep_due;
   logic [16:0]       score_sum;
   logic [15:0]       score_sat, step_sel;
   entry_type         dec_ent;
   logic [DEST_W-1:0] slot_dst_base;

   tpd_csr u_csr (
      .clock, .reset, .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr,
      .csr_pwdata, .csr_prdata, .csr_pready, .cfg
   );

   tpd_hash #(.HASH_BITS(HASH_BITS)) u_hash (
      .clock, .reset,
      .run    (state_ff == S_HASH),
      .ip     (src_ff[15:0]),
      .done   (hash_done),
      .bucket (bucket)
   );

   tpd_store #(.SLOTS(SLOTS), .SLOT_W(SLOT_W), .DESTS(DESTS), .DEST_W(DEST_W)) u_store (
      .clock, .ent_raddr, .ent_rdata, .ent_we, .ent_waddr, .ent_wdata,
      .dst_raddr, .dst_rdata, .dst_we, .dst_waddr, .dst_wdata (dst_ff)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign req_acc    = req_tvalid & req_tready;
   assign sweep_due  = {1'b0, last_ff} + {1'b0, cfg.cleanup_interval};
   assign way_slot   = base_ff + SLOT_W'(way_ff);
   assign slot_dst_base = DEST_W'(slot_ff) * DEST_W'(HOSTS_PER_ENTRY);

   assign step_sel  = ok_ff ? cfg.success_step : cfg.failure_step;
   assign score_sum = {ent_ff.score[15], ent_ff.score} + {step_sel[15], step_sel};
   assign score_sat = (score_sum[16] != score_sum[15]) ?
                      (score_sum[16] ? 16'h8000 : 16'h7FFF) : score_sum[15:0];

   always_comb begin
      dec_ent = ent_ff;
      if ($signed(ent_ff.score) < $signed(cfg.lower_threshold)) begin
         dec_ent.decision = DEC_BENIGN;
         dec_ent.expiry   = later(now_ff, cfg.benign_lifetime);
      end else if ($signed(ent_ff.score) > $signed(cfg.upper_threshold)) begin
         dec_ent.decision = DEC_SCANNER;
         dec_ent.expiry   = later(now_ff, cfg.scanner_lifetime);
      end
   end

   always_comb begin
      state_in    = state_ff;
      idx_in      = idx_ff;
      base_in     = base_ff;
      slot_in     = slot_ff;
      free_in     = free_ff;
      has_free_in = has_free_ff;
      way_in      = way_ff;
      host_in     = host_ff;
      src_in      = src_ff;
      dst_in      = dst_ff;
      now_in      = now_ff;
      ok_in       = ok_ff;
      last_in     = last_ff;
      ent_in      = ent_ff;
      res_in      = res_ff;
      out_in      = out_ff;
      out_vld_in  = out_vld_ff & ~rsp_tready;
      ent_raddr   = idx_ff;
      ent_we      = 1'b0;
      ent_waddr   = slot_ff;
      ent_wdata   = ent_ff;
      dst_raddr   = slot_dst_base + DEST_W'(host_ff);
      dst_we      = 1'b0;
      dst_waddr   = slot_dst_base + DEST_W'(ent_ff.hosts);

      unique case (state_ff)
         S_CLEAR: begin
            ent_we    = 1'b1;
            ent_waddr = idx_ff;
            ent_wdata = '0;
            idx_in    = idx_ff + 1'b1;
            if (idx_ff == SLOT_W'(SLOTS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_acc) begin
               src_in = req_tdata[31:0];
               dst_in = req_tdata[63:32];
               now_in = req_tdata[95:64];
               ok_in  = req_tuser[1] & req_tuser[2];
               idx_in = '0;
               if (!req_tuser[0]) begin
                  res_in        = '0;
                  res_in.status = STAT_IGNORED;
                  res_in.source = req_tdata[31:0];
                  state_in      = S_EMIT;
               end else if (sweep_due < {1'b0, req_tdata[95:64]}) begin
                  last_in  = req_tdata[95:64];
                  state_in = S_SWEEP_RD;
               end else begin
                  state_in = S_HASH;
               end
            end
         end
         S_SWEEP_RD: begin
            state_in = S_SWEEP_WR;
         end
         S_SWEEP_WR: begin
            ent_waddr       = idx_ff;
            ent_wdata       = ent_rdata;
            ent_wdata.valid = 1'b0;
            ent_we          = ent_rdata.valid && (now_ff > ent_rdata.expiry);
            idx_in          = idx_ff + 1'b1;
            state_in        = (idx_ff == SLOT_W'(SLOTS - 1)) ? S_HASH : S_SWEEP_RD;
         end
         S_HASH: begin
            if (hash_done) begin
               base_in     = SLOT_W'(bucket) * SLOT_W'(WAYS);
               way_in      = '0;
               has_free_in = 1'b0;
               state_in    = S_WAY_RD;
            end
         end
         S_WAY_RD: begin
            ent_raddr = way_slot;
            state_in  = S_WAY_CHK;
         end
         S_WAY_CHK: begin
            if (ent_rdata.valid && ent_rdata.source == src_ff) begin
               slot_in  = way_slot;
               ent_in   = ent_rdata;
               state_in = S_UPDATE;
            end else begin
               if (!ent_rdata.valid && !has_free_ff) begin
                  has_free_in = 1'b1;
                  free_in     = way_slot;
               end
               if (way_ff == WAY_W'(WAYS - 1)) begin
                  if (has_free_in) begin
                     slot_in         = has_free_ff ? free_ff : way_slot;
                     ent_in          = '0;
                     ent_in.valid    = 1'b1;
                     ent_in.source   = src_ff;
                     ent_in.mask     = ALL_ONES;
                     ent_in.decision = DEC_PENDING;
                     state_in        = S_UPDATE;
                  end else begin
                     res_in        = '0;
                     res_in.status = STAT_FULL;
                     res_in.source = src_ff;
                     state_in      = S_EMIT;
                  end
               end else begin
                  way_in   = way_ff + 1'b1;
                  state_in = S_WAY_RD;
               end
            end
         end
         S_UPDATE: begin
            if (ent_ff.decision != DEC_PENDING) begin
               res_in   = entry_result(STAT_DECIDED, ent_ff);
               state_in = S_EMIT;
            end else begin
               if (ok_ff) begin
                  ent_in.success = sat_inc(ent_ff.success);
               end else begin
                  ent_in.failed = sat_inc(ent_ff.failed);
               end
               ent_in.expiry = later(now_ff, cfg.pending_lifetime);
               host_in       = '0;
               state_in      = (ent_ff.hosts == '0) ? S_INSERT : S_HOST_RD;
            end
         end
         S_HOST_RD: begin
            state_in = S_HOST_CHK;
         end
         S_HOST_CHK: begin
            if (dst_rdata == dst_ff) begin
               ent_we   = 1'b1;
               res_in   = entry_result(STAT_REPEAT, ent_ff);
               state_in = S_EMIT;
            end else begin
               host_in  = host_ff + 1'b1;
               state_in = (host_in >= ent_ff.hosts) ? S_INSERT : S_HOST_RD;
            end
         end
         S_INSERT: begin
            if (ent_ff.hosts < HC_W'(HOSTS_PER_ENTRY)) begin
               dst_we       = 1'b1;
               ent_in.hosts = ent_ff.hosts + 1'b1;
            end
            ent_in.score = score_sat;
            if (ent_ff.hosts == '0) begin
               ent_in.subnet = dst_ff;
               state_in      = S_DECIDE;
            end else begin
               state_in = S_AGG;
            end
         end
         S_AGG: begin
            // widen the prefix one bit per cycle until it covers dst
            if ((ent_ff.subnet & ent_ff.mask) != (dst_ff & ent_ff.mask)) begin
               ent_in.mask   = ent_ff.mask << 1;
               ent_in.subnet = ent_ff.subnet & (ent_ff.mask << 1);
            end else begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            ent_in    = dec_ent;
            ent_we    = 1'b1;
            ent_wdata = dec_ent;
            if (dec_ent.decision == DEC_BENIGN) begin
               res_in = entry_result(STAT_BENIGN, dec_ent);
            end else if (dec_ent.decision == DEC_SCANNER) begin
               res_in = entry_result(STAT_SCANNER, dec_ent);
            end else begin
               res_in = entry_result(STAT_PENDING, dec_ent);
            end
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (!out_vld_ff || rsp_tready) begin
               out_in     = res_ff;
               out_vld_in = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_CLEAR;
         idx_ff     <= '0;
         last_ff    <= '0;
         out_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         idx_ff     <= idx_in;
         last_ff    <= last_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      base_ff     <= base_in;
      slot_ff     <= slot_in;
      free_ff     <= free_in;
      has_free_ff <= has_free_in;
      way_ff      <= way_in;
      host_ff     <= host_in;
      src_ff      <= src_in;
      dst_ff      <= dst_in;
      now_ff      <= now_in;
      ok_ff       <= ok_in;
      ent_ff      <= ent_in;
      res_ff      <= res_in;
      out_ff      <= out_in;
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tuser  = out_ff.status;
   assign rsp_tdata  = {out_ff.score, out_ff.success, out_ff.failed,
                        out_ff.mask, out_ff.subnet, out_ff.source};

   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> !req_tready)
      else $error("request accepted during clearing pass");

   a_leave_idle: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> (state_ff != S_IDLE))
      else $error("accepted request did not start processing");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser != 3'd7))
      else $error("undefined result status");

   a_one_write: assert property (@(posedge clock) disable iff (reset)
      dst_we |-> (state_ff == S_INSERT) && !ent_we)
      else $error("destination write outside insert step");
endmodule
`default_nettype wire
